// ----- rtl/hrwe_pkg.sv -----
// shared types, constants and the nibble decoder of the hex record word extractor
package hrwe_pkg;

   localparam int RING_DEPTH_DEFAULT = 64;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [9:0] POS_MAX    = 10'd1023;
   localparam logic [9:0] DATA_START = 10'd9;

   // header character positions
   localparam logic [9:0] POS_COUNT_HI = 10'd1;
   localparam logic [9:0] POS_COUNT_LO = 10'd2;
   localparam logic [9:0] POS_ADDR_3   = 10'd3;
   localparam logic [9:0] POS_ADDR_2   = 10'd4;
   localparam logic [9:0] POS_ADDR_1   = 10'd5;
   localparam logic [9:0] POS_ADDR_0   = 10'd6;

   // phase of a data character within its four-character word
   localparam logic [1:0] PHASE_LOW_HI  = 2'd1;
   localparam logic [1:0] PHASE_LOW_LO  = 2'd2;
   localparam logic [1:0] PHASE_HIGH_HI = 2'd3;
   localparam logic [1:0] PHASE_HIGH_LO = 2'd0;

   typedef enum logic [1:0] {
      KIND_COUNT = 2'd0,
      KIND_ADDR  = 2'd1,
      KIND_WORD  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [5:0]  slot_index;
      logic [15:0] entry_value;
      kind_type    entry_kind;
      logic [15:0] words_seen;
   } entry_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_char;
   } char_item_type;

   // uppercase hex digit to nibble, anything else reads as zero
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h37);
      end
      return n;
   endfunction

endpackage

// ----- rtl/hex_record_word_extractor.sv -----
// top level of the hex record word extractor
// Reads hex record text one character per req transfer (req_rx_char) and
// produces at most one rsp transfer per character: the byte count (kind 0)
// at the second character after a colon, the 16-bit load address (kind 1)
// at the sixth, and one little-endian data word (kind 2) for every four
// data characters. Each entry carries its ring slot and the running count
// of data words. Record type and checksum produce nothing.
// A req transfer lands in the input register, and the core loads its entry
// from there into the result register, which drives rsp_valid. Throughput:
// one character per cycle while no entry waits on a stalled rsp, set by the
// single update of the position and accumulator registers.
// A stalled rsp holds its entry; characters that produce no entry still
// flow, and req_stall rises only when an entry cannot be handed on.
// Synchronous reset empties both registers and clears the position,
// accumulators, ring slot and word count to zero.
module hex_record_word_extractor #(
   parameter int RING_DEPTH = hrwe_pkg::RING_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_slot_index,
   output logic [15:0] rsp_entry_value,
   output logic [1:0]  rsp_entry_kind,
   output logic [15:0] rsp_words_seen
);

   hrwe_pkg::char_item_type item;
   hrwe_pkg::entry_type     entry;
   logic                    core_fire;
   logic                    core_emit;
   logic                    out_ready;

   hrwe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_char(req_rx_char),
      .core_fire  (core_fire),
      .item       (item)
   );

   hrwe_core #(
      .RING_DEPTH(RING_DEPTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .out_ready(out_ready),
      .fire     (core_fire),
      .emit     (core_emit),
      .entry    (entry)
   );

   hrwe_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .load           (core_fire && core_emit),
      .entry          (entry),
      .out_ready      (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot_index (rsp_slot_index),
      .rsp_entry_value(rsp_entry_value),
      .rsp_entry_kind (rsp_entry_kind),
      .rsp_words_seen (rsp_words_seen)
   );

`ifndef SYNTHESIS
   // byte count is a single byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_kind == hrwe_pkg::KIND_COUNT |-> rsp_entry_value[15:8] == 8'd0)
      else $error("byte count entry wider than a byte");

   // input side only stalls while holding a character
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item.valid)
      else $error("req stalled with empty input register");

   // an entry is only produced when the result register can take it
   assert property (@(posedge clock) disable iff (reset)
      core_fire && core_emit |-> out_ready)
      else $error("entry produced while result register full");

   // a held result frees the input side only for characters without an entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && core_fire |-> !core_emit)
      else $error("core fired an entry into a stalled result register");
`endif

endmodule

// ----- rtl/hrwe_in_stage.sv -----
// input register holding one received character
module hrwe_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_char,
   input  logic                   core_fire,
   output hrwe_pkg::char_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       take;

   // free slot, or the held character leaves this cycle
   assign req_stall = valid_ff && !core_fire;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (take) begin
         valid_in = 1'b1;
         char_in  = req_rx_char;
      end else if (core_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign item.valid   = valid_ff;
   assign item.rx_char = char_ff;

endmodule

// ----- rtl/hrwe_core.sv -----
// record position tracking, accumulators and entry generation
module hrwe_core #(
   parameter int RING_DEPTH = hrwe_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hrwe_pkg::char_item_type item,
   input  logic                    out_ready,
   output logic                    fire,
   output logic                    emit,
   output hrwe_pkg::entry_type     entry
);

   localparam int SlotWidth = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [SlotWidth:0] SlotLast = (SlotWidth + 1)'(RING_DEPTH - 1);

   logic [9:0]           pos_ff, pos_in;
   logic [9:0]           end_ff, end_in;
   logic [15:0]          low_ff, low_in;
   logic [15:0]          high_ff, high_in;
   logic [SlotWidth-1:0] slot_ff, slot_in;
   logic [15:0]          tally_ff, tally_in;

   logic [9:0]           pos;
   logic [3:0]           nib;
   logic [15:0]          low_sum;
   logic [7:0]           byte_sum;
   logic [15:0]          high_word;
   logic [15:0]          value;
   hrwe_pkg::kind_type   kind;
   logic [SlotWidth+5:0] slot_ext;
   logic [SlotWidth:0]   slot_wide;
   logic [9:0]           end_calc;

   assign nib      = hrwe_pkg::nibble_of(item.rx_char);
   assign pos      = (item.rx_char == hrwe_pkg::CHAR_COLON) ? 10'd0 : pos_ff;
   assign low_sum  = low_ff + {12'd0, nib};
   assign byte_sum = low_ff[7:0] + {4'd0, nib};
   assign end_calc = hrwe_pkg::DATA_START + {low_sum[8:0], 1'b0};
   // high byte completes and joins the low byte
   assign high_word = {8'(high_ff[7:0] + {4'd0, nib}), 8'h00};

   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      end_in   = end_ff;
      tally_in = tally_ff;
      emit     = 1'b0;
      value    = low_ff;
      kind     = hrwe_pkg::KIND_COUNT;

      case (pos)
         hrwe_pkg::POS_COUNT_HI: low_in = {8'd0, nib, 4'd0};
         hrwe_pkg::POS_COUNT_LO: begin
            low_in = low_sum;
            end_in = end_calc;
            emit   = 1'b1;
            value  = low_sum;
            kind   = hrwe_pkg::KIND_COUNT;
         end
         hrwe_pkg::POS_ADDR_3: low_in = {8'd0, nib, 4'd0};
         hrwe_pkg::POS_ADDR_2: low_in = {byte_sum, 8'h00};
         hrwe_pkg::POS_ADDR_1: low_in = low_ff + {8'd0, nib, 4'd0};
         hrwe_pkg::POS_ADDR_0: begin
            low_in = low_sum;
            emit   = 1'b1;
            value  = low_sum;
            kind   = hrwe_pkg::KIND_ADDR;
         end
         default: ;
      endcase

      if (pos >= hrwe_pkg::DATA_START && pos < end_ff) begin
         case (pos[1:0])
            hrwe_pkg::PHASE_LOW_HI:  low_in  = {8'd0, nib, 4'd0};
            hrwe_pkg::PHASE_LOW_LO:  low_in  = low_sum;
            hrwe_pkg::PHASE_HIGH_HI: high_in = {8'd0, nib, 4'd0};
            default: begin
               high_in  = high_word;
               low_in   = low_ff + high_word;
               tally_in = tally_ff + 16'd1;
               emit     = 1'b1;
               value    = low_ff + high_word;
               kind     = hrwe_pkg::KIND_WORD;
            end
         endcase
      end
   end

   // a character with no entry never waits on the output side
   assign fire = item.valid && (!emit || out_ready);

   assign slot_wide = {1'b0, slot_ff};
   always_comb begin
      slot_in = slot_ff;
      if (emit) begin
         slot_in = (slot_wide >= SlotLast) ? '0 : SlotWidth'(slot_wide + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         end_ff   <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
         slot_ff  <= '0;
         tally_ff <= '0;
      end else if (fire) begin
         pos_ff   <= (pos < hrwe_pkg::POS_MAX) ? pos + 10'd1 : pos;
         end_ff   <= end_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         slot_ff  <= slot_in;
         tally_ff <= tally_in;
      end
   end

   assign slot_ext          = {6'd0, slot_ff};
   assign entry.slot_index  = slot_ext[5:0];
   assign entry.entry_value = value;
   assign entry.entry_kind  = kind;
   assign entry.words_seen  = tally_in;

endmodule

// ----- rtl/hrwe_out_stage.sv -----
// result register facing the receiver
module hrwe_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  hrwe_pkg::entry_type entry,
   output logic                out_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [5:0]          rsp_slot_index,
   output logic [15:0]         rsp_entry_value,
   output logic [1:0]          rsp_entry_kind,
   output logic [15:0]         rsp_words_seen
);

   logic                valid_ff, valid_in;
   hrwe_pkg::entry_type entry_ff, entry_in;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (load) begin
         valid_in = 1'b1;
         entry_in = entry;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_slot_index  = entry_ff.slot_index;
   assign rsp_entry_value = entry_ff.entry_value;
   assign rsp_entry_kind  = entry_ff.entry_kind;
   assign rsp_words_seen  = entry_ff.words_seen;

endmodule

// ----- sim/tb_hex_record_word_extractor.sv -----
// testbench of the hex record word extractor: record text in, ring entries checked
`timescale 1ns / 1ps

class record_entry_tracker;
   logic [9:0]  char_pos   = '0;
   logic [9:0]  data_end   = '0;
   logic [15:0] acc_lo     = '0;
   logic [15:0] acc_hi     = '0;
   logic [5:0]  next_slot  = '0;
   logic [15:0] word_count = '0;
   hrwe_pkg::entry_type awaited[$];
   int          error_count = 0;
   int          chars_taken = 0;
   int          kind_seen[3];

   function logic [3:0] digit_value(logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return c[3:0];
      if (c inside {[8'h41:8'h46]}) return c[3:0] + 4'd9;
      return 4'd0;
   endfunction

   function void note_entry(logic [15:0] value, hrwe_pkg::kind_type kind);
      hrwe_pkg::entry_type next_entry;
      next_entry.slot_index  = next_slot;
      next_entry.entry_value = value;
      next_entry.entry_kind  = kind;
      next_entry.words_seen  = word_count;
      awaited.push_back(next_entry);
      next_slot = (int'(next_slot) + 1 >= hrwe_pkg::RING_DEPTH_DEFAULT) ?
                  6'd0 : next_slot + 6'd1;
   endfunction

   // one accepted character moves the record position on
   function void take_char(logic [7:0] c);
      logic [3:0] nib;
      logic [9:0] pos;
      chars_taken++;
      nib = digit_value(c);
      if (c == hrwe_pkg::CHAR_COLON) char_pos = '0;
      pos = char_pos;
      case (pos)
         hrwe_pkg::POS_COUNT_HI: acc_lo = {8'd0, nib, 4'd0};
         hrwe_pkg::POS_COUNT_LO: begin
            acc_lo   = acc_lo + 16'(nib);
            data_end = hrwe_pkg::DATA_START + {acc_lo[8:0], 1'b0};
            note_entry(acc_lo, hrwe_pkg::KIND_COUNT);
         end
         hrwe_pkg::POS_ADDR_3: acc_lo = {8'd0, nib, 4'd0};
         hrwe_pkg::POS_ADDR_2: acc_lo = (acc_lo + 16'(nib)) << 8;
         hrwe_pkg::POS_ADDR_1: acc_lo = acc_lo + {8'd0, nib, 4'd0};
         hrwe_pkg::POS_ADDR_0: begin
            acc_lo = acc_lo + 16'(nib);
            note_entry(acc_lo, hrwe_pkg::KIND_ADDR);
         end
         default: ;
      endcase
      if (pos >= hrwe_pkg::DATA_START && pos < data_end) begin
         case (pos[1:0])
            hrwe_pkg::PHASE_LOW_HI:  acc_lo = {8'd0, nib, 4'd0};
            hrwe_pkg::PHASE_LOW_LO:  acc_lo = acc_lo + 16'(nib);
            hrwe_pkg::PHASE_HIGH_HI: acc_hi = {8'd0, nib, 4'd0};
            hrwe_pkg::PHASE_HIGH_LO: begin
               // high byte joins the low byte, little-endian
               acc_hi     = (acc_hi + 16'(nib)) << 8;
               acc_lo     = acc_lo + acc_hi;
               word_count = word_count + 16'd1;
               note_entry(acc_lo, hrwe_pkg::KIND_WORD);
            end
         endcase
      end
      // position holds at its top instead of wrapping
      if (char_pos < hrwe_pkg::POS_MAX) char_pos = char_pos + 10'd1;
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         error_count++;
      end
   endfunction

   function void check_entry(logic [5:0] slot, logic [15:0] value, logic [1:0] kind,
                             logic [15:0] seen);
      hrwe_pkg::entry_type want;
      if (awaited.size() == 0) begin
         $display("%0t: entry with nothing expected: slot %0d value %h kind %0d words %0d",
                  $time, slot, value, kind, seen);
         error_count++;
         return;
      end
      want = awaited.pop_front();
      compare_field("slot_index", want.slot_index, slot);
      compare_field("entry_value", want.entry_value, value);
      compare_field("entry_kind", int'(want.entry_kind), kind);
      compare_field("words_seen", want.words_seen, seen);
      kind_seen[int'(want.entry_kind)]++;
   endfunction
endclass

module tb_hex_record_word_extractor;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_GOAL = 1550;
   localparam int TOTAL_GOAL  = 1800;
   localparam int LONG_RUN    = 540;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_char;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [5:0]  rsp_slot_index;
   logic [15:0] rsp_entry_value;
   logic [1:0]  rsp_entry_kind;
   logic [15:0] rsp_words_seen;

   record_entry_tracker tracker = new();

   bit send_idling = 1'b1;
   bit rsp_idling  = 1'b1;
   int long_hold   = 0;
   int input_stall_cycles = 0;

   hex_record_word_extractor dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_char     (req_rx_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_entry_value (rsp_entry_value),
      .rsp_entry_kind  (rsp_entry_kind),
      .rsp_words_seen  (rsp_words_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // transfers on both channels are taken at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.take_char(req_rx_char);
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            tracker.check_entry(rsp_slot_index, rsp_entry_value, rsp_entry_kind,
                                rsp_words_seen);
         end
      end
   end

   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [7:0] hex_char(logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
   endfunction

   // mostly uppercase digits, now and then lowercase or any byte but a colon
   function automatic logic [7:0] record_char();
      int roll;
      logic [7:0] c;
      roll = $urandom_range(0, 31);
      if (roll == 0) return 8'h61 + 8'($urandom_range(0, 5));
      if (roll == 1) begin
         c = 8'($urandom_range(0, 255));
         return (c == hrwe_pkg::CHAR_COLON) ? 8'h47 : c;
      end
      return hex_char(4'($urandom_range(0, 15)));
   endfunction

   task automatic send_char(input logic [7:0] c);
      if (send_idling && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_char <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_char(s[i]);
   endtask

   // cut below zero sends the whole record, otherwise only its first cut characters
   task automatic send_record(input int count, input int cut);
      logic [7:0] text[$];
      logic [7:0] byte_count;
      logic [15:0] addr;
      byte_count = 8'(count);
      addr = 16'($urandom);
      text.push_back(hrwe_pkg::CHAR_COLON);
      text.push_back(hex_char(byte_count[7:4]));
      text.push_back(hex_char(byte_count[3:0]));
      for (int i = 3; i >= 0; i--) text.push_back(hex_char(addr[4*i +: 4]));
      text.push_back(8'h30);
      text.push_back(($urandom_range(0, 3) == 0) ? record_char() : 8'h30);
      repeat (2 * count) text.push_back(record_char());
      repeat (2) text.push_back(hex_char(4'($urandom_range(0, 15))));
      if ($urandom_range(0, 1) == 1) begin
         text.push_back(8'h0D);
         text.push_back(8'h0A);
      end
      foreach (text[i]) begin
         if (cut >= 0 && i >= cut) break;
         send_char(text[i]);
      end
   endtask

   task automatic send_noise(input int n);
      repeat (n) begin
         send_char(($urandom_range(0, 7) == 0) ? hrwe_pkg::CHAR_COLON
                                                : 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (tracker.awaited.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int pick;
      bit did_hold;
      bit did_drain;
      bit did_long_record;
      did_hold = 1'b0;
      did_drain = 1'b0;
      did_long_record = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_char = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // text ahead of any colon, all-ones address and word, lowercase in the header
      send_text("xF0");
      send_text(":02FFFF00FFFFC3");
      send_text(":0a0f00");
      wait_drained();

      while (tracker.chars_taken < RANDOM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            send_record($urandom_range(0, 16), -1);
         end else if (pick < 78) begin
            send_record($urandom_range(0, 16), $urandom_range(1, 24));
         end else if (pick < 86) begin
            send_noise($urandom_range(1, 12));
         end else if (pick < 89) begin
            send_record($urandom_range(17, 48), -1);
         end else begin
            // a stretch with no gaps from the sender
            send_idling = 1'b0;
            repeat (2) send_record($urandom_range(0, 16), -1);
            send_idling = 1'b1;
         end

         if (!did_hold && tracker.chars_taken > 200) begin
            // receiver holds off while records keep coming, so the input backs up
            did_hold = 1'b1;
            long_hold = 150;
            send_idling = 1'b0;
            repeat (6) send_record(8, -1);
            send_idling = 1'b1;
         end
         if (!did_drain && tracker.chars_taken > 350) begin
            did_drain = 1'b1;
            wait_drained();
         end
         if (!did_long_record && tracker.chars_taken > 450) begin
            // longest record, then digits with no colon run the position into saturation
            did_long_record = 1'b1;
            send_record(255, -1);
            repeat (LONG_RUN) send_char(hex_char(4'($urandom_range(0, 15))));
         end
      end

      wait_drained();
      send_idling = 1'b0;
      rsp_idling = 1'b0;
      while (tracker.chars_taken < TOTAL_GOAL) begin
         send_record($urandom_range(0, 16), -1);
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("characters: %0d, counts: %0d, addresses: %0d, data words: %0d",
               tracker.chars_taken, tracker.kind_seen[int'(hrwe_pkg::KIND_COUNT)],
               tracker.kind_seen[int'(hrwe_pkg::KIND_ADDR)],
               tracker.kind_seen[int'(hrwe_pkg::KIND_WORD)]);
      $display("input held back for %0d cycles, final word tally %0d, final ring slot %0d",
               input_stall_cycles, tracker.word_count, tracker.next_slot);
      if (tracker.error_count == 0 && tracker.awaited.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
